// ===== rtl/core/cle_pkg.sv =====
package cle_pkg;

  // Line geometry and result budget
  localparam int LINE_CHARS_DEF = 24;
  localparam int MAX_RESULTS    = 64;
  localparam int ENTRY_W        = 10;

  // Byte codes
  localparam logic [7:0] K_BS       = 8'h08;
  localparam logic [7:0] K_BEL      = 8'h07;
  localparam logic [7:0] K_NL       = 8'h0A;
  localparam logic [7:0] K_ESC      = 8'd27;
  localparam logic [7:0] K_SPACE    = 8'h20;
  localparam logic [7:0] K_RUB      = 8'h7F;
  localparam logic [7:0] K_LBRACKET = 8'h5B;
  localparam logic [7:0] K_SS3      = 8'h4F;
  localparam logic [7:0] K_RIGHT    = 8'd67;
  localparam logic [7:0] K_LEFT     = 8'd68;
  localparam logic [7:0] K_INS      = 8'd50;
  localparam logic [7:0] K_DEL      = 8'd51;
  localparam logic [7:0] K_HOME     = 8'h48;
  localparam logic [7:0] K_END      = 8'h46;
  localparam logic [7:0] K_LEAD1    = 8'hC2;
  localparam logic [7:0] K_LEAD2    = 8'hC3;

  // Lead codes kept in entry bits 9..8
  localparam logic [1:0] LEAD_NONE = 2'd0;
  localparam logic [1:0] LEAD_C2   = 2'd1;
  localparam logic [1:0] LEAD_C3   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN_RD,
    ST_SPAN_ACC,
    ST_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_WRITE,
    ST_PRE,
    ST_PRE_TAIL,
    ST_ECHO_RD,
    ST_ECHO_LEAD,
    ST_ECHO_BYTE,
    ST_POST,
    ST_BACK,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    ESC_IDLE,
    ESC_START,
    ESC_CSI,
    ESC_SS3,
    ESC_INS_TRAIL,
    ESC_DEL_TRAIL
  } esc_t;

  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_BYTE,
    PRE_CELL
  } pre_t;

  // Word request from sequencer to result stage
  typedef struct packed {
    logic       req;
    logic [7:0] data;
    logic       kind;
    logic [5:0] len;
    logic       flush;
  } cle_emit_t;

  typedef struct packed {
    logic emit_ok;
    logic flush_ok;
  } cle_ack_t;

  // Lead byte for a nonzero lead code
  function automatic logic [7:0] lead_byte(input logic [1:0] code);
    lead_byte = (code == LEAD_C2) ? K_LEAD1 : K_LEAD2;
  endfunction

endpackage

// ===== rtl/core/cle_line_mem.sv =====
module cle_line_mem #(
  parameter int LINE_CHARS = cle_pkg::LINE_CHARS_DEF,
  localparam int AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [cle_pkg::ENTRY_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [cle_pkg::ENTRY_W-1:0] wr_data
);
  import cle_pkg::*;

  logic [ENTRY_W-1:0] mem [LINE_CHARS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/cle_out.sv =====
module cle_out (
  input  logic                clk,
  input  logic                rst,
  input  cle_pkg::cle_emit_t  emit,
  output cle_pkg::cle_ack_t   ack,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_kind,
  output logic [5:0]          line_length,
  output logic                last
);
  import cle_pkg::*;

  // One word held back so the final word of an item can be marked last
  logic       hold_v;
  logic [7:0] hold_byte;
  logic       hold_kind;
  logic [5:0] hold_len;
  logic       out_free;
  logic       emit_fire;
  logic       flush_fire;

  always_comb begin
    out_free     = !out_valid || out_ready;
    ack.emit_ok  = !hold_v || out_free;
    ack.flush_ok = !hold_v || out_free;
    emit_fire    = emit.req && ack.emit_ok;
    flush_fire   = emit.flush && ack.flush_ok;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v    <= 1'b0;
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      hold_v <= 1'b1;
      if (hold_v) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end else if (flush_fire && hold_v) begin
      hold_v    <= 1'b0;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      hold_byte <= emit.data;
      hold_kind <= emit.kind;
      hold_len  <= emit.len;
    end
    if ((emit_fire || flush_fire) && hold_v) begin
      out_byte    <= hold_byte;
      out_kind    <= hold_kind;
      line_length <= hold_len;
      last        <= flush_fire;
    end
  end

endmodule

// ===== rtl/core/cle_seq.sv =====
module cle_seq #(
  parameter int LINE_CHARS = cle_pkg::LINE_CHARS_DEF,
  localparam int AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  rx_byte,
  output logic                        mem_rd_en,
  output logic [AW-1:0]               mem_rd_addr,
  input  logic [cle_pkg::ENTRY_W-1:0] mem_rd_data,
  output logic                        mem_wr_en,
  output logic [AW-1:0]               mem_wr_addr,
  output logic [cle_pkg::ENTRY_W-1:0] mem_wr_data,
  output cle_pkg::cle_emit_t          emit,
  input  cle_pkg::cle_ack_t           ack
);
  import cle_pkg::*;

  localparam int CW = $clog2(LINE_CHARS + 1);
  localparam int SW = $clog2(2 * LINE_CHARS + 1);

  state_t state, state_next;

  // Architectural state
  logic [CW-1:0] cc;
  logic [CW-1:0] cur;
  logic          ins;
  esc_t          phase;
  logic [1:0]    lead;

  // Plan of the current item
  logic [CW-1:0]      sp_i, sp_b;
  logic [SW-1:0]      span;
  logic [7:0]         extra;
  logic               chk_en;
  logic               sh_up;
  logic [CW-1:0]      sh_dst, sh_cnt;
  logic               wr_p;
  logic [ENTRY_W-1:0] ent;
  pre_t               pre_mode;
  logic [7:0]         pre_byte;
  logic [CW-1:0]      e_i, e_b;
  logic               e_kind;
  logic               post_en;
  logic [7:0]         post_byte;
  logic               post_kind;
  logic [CW-1:0]      back_cnt;
  logic [CW-1:0]      ncc, ncur;

  logic          accept;
  logic          do_enter;
  logic [7:0]    e_w;
  logic [CW-1:0] gap;
  logic [CW-1:0] sh_src;
  logic [1:0]    rd_code;
  logic          fire;
  logic [5:0]    llen;

  // Decode helpers
  always_comb begin
    accept   = in_valid && in_ready;
    do_enter = (lead != LEAD_NONE) ||
               (phase == ESC_IDLE && rx_byte >= K_SPACE && rx_byte < K_RUB);
    e_w      = (lead != LEAD_NONE) ? 8'd2 : 8'd1;
    gap      = cc - cur;
    sh_src   = sh_up ? sh_dst - CW'(1) : sh_dst + CW'(1);
    rd_code  = mem_rd_data[9:8];
    fire     = emit.req && ack.emit_ok;
    llen     = 6'(span) + 6'd1;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (accept) state_next = ST_SPAN_RD;
      ST_SPAN_RD:   state_next = (sp_i < sp_b) ? ST_SPAN_ACC : ST_CHECK;
      ST_SPAN_ACC:  state_next = ST_SPAN_RD;
      ST_CHECK:     state_next = ST_SHIFT_RD;
      ST_SHIFT_RD:  state_next = (sh_cnt != '0) ? ST_SHIFT_WR : ST_WRITE;
      ST_SHIFT_WR:  state_next = ST_SHIFT_RD;
      ST_WRITE:     state_next = ST_PRE;
      ST_PRE: begin
        if (pre_mode == PRE_NONE) begin
          state_next = ST_ECHO_RD;
        end else if (fire) begin
          state_next = (pre_mode == PRE_CELL && ent[9:8] != LEAD_NONE) ?
                       ST_PRE_TAIL : ST_ECHO_RD;
        end
      end
      ST_PRE_TAIL:  if (fire) state_next = ST_ECHO_RD;
      ST_ECHO_RD:   state_next = (e_i < e_b) ? ST_ECHO_LEAD : ST_POST;
      ST_ECHO_LEAD: begin
        if (fire) state_next = (rd_code != LEAD_NONE) ? ST_ECHO_BYTE : ST_ECHO_RD;
      end
      ST_ECHO_BYTE: if (fire) state_next = ST_ECHO_RD;
      ST_POST:      if (!post_en || fire) state_next = ST_BACK;
      ST_BACK:      if (back_cnt == '0) state_next = ST_FIN;
      ST_FIN:       if (ack.flush_ok) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs: memory ports and words
  always_comb begin
    in_ready    = (state == ST_IDLE);
    mem_rd_en   = 1'b0;
    mem_rd_addr = sp_i[AW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = sh_dst[AW-1:0];
    mem_wr_data = mem_rd_data;
    emit.req    = 1'b0;
    emit.data   = K_BS;
    emit.kind   = 1'b0;
    emit.flush  = 1'b0;
    case (state)
      ST_SPAN_RD: begin
        mem_rd_en = (sp_i < sp_b);
      end
      ST_SHIFT_RD: begin
        mem_rd_en   = (sh_cnt != '0);
        mem_rd_addr = sh_src[AW-1:0];
      end
      ST_SHIFT_WR: begin
        mem_wr_en = 1'b1;
      end
      ST_WRITE: begin
        mem_wr_en   = wr_p;
        mem_wr_addr = cur[AW-1:0];
        mem_wr_data = ent;
      end
      ST_PRE: begin
        emit.req = (pre_mode != PRE_NONE);
        if (pre_mode == PRE_CELL) begin
          emit.data = (ent[9:8] != LEAD_NONE) ? lead_byte(ent[9:8]) : ent[7:0];
        end else begin
          emit.data = pre_byte;
        end
      end
      ST_PRE_TAIL: begin
        emit.req  = 1'b1;
        emit.data = ent[7:0];
      end
      ST_ECHO_RD: begin
        mem_rd_en   = (e_i < e_b);
        mem_rd_addr = e_i[AW-1:0];
      end
      ST_ECHO_LEAD: begin
        emit.req  = 1'b1;
        emit.data = (rd_code != LEAD_NONE) ? lead_byte(rd_code) : mem_rd_data[7:0];
        emit.kind = e_kind;
      end
      ST_ECHO_BYTE: begin
        emit.req  = 1'b1;
        emit.data = mem_rd_data[7:0];
        emit.kind = e_kind;
      end
      ST_POST: begin
        emit.req  = post_en;
        emit.data = post_byte;
        emit.kind = post_kind;
      end
      ST_BACK: begin
        emit.req = (back_cnt != '0);
      end
      ST_FIN: begin
        emit.flush = 1'b1;
      end
      default: ;
    endcase
    emit.len = emit.kind ? llen : 6'd0;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cc    <= '0;
      cur   <= '0;
      ins   <= 1'b0;
      phase <= ESC_IDLE;
      lead  <= LEAD_NONE;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && accept) begin
        phase <= ESC_IDLE;
        lead  <= LEAD_NONE;
        if (!do_enter) begin
          case (phase)
            ESC_START: begin
              if (rx_byte == K_LBRACKET) begin
                phase <= ESC_CSI;
              end else if (rx_byte == K_SS3) begin
                phase <= ESC_SS3;
              end
            end
            ESC_CSI: begin
              if (rx_byte == K_INS) begin
                ins   <= ~ins;
                phase <= ESC_INS_TRAIL;
              end else if (rx_byte == K_DEL) begin
                phase <= ESC_DEL_TRAIL;
              end
            end
            ESC_IDLE: begin
              if (rx_byte == K_ESC) begin
                phase <= ESC_START;
              end else if (rx_byte == K_LEAD1) begin
                lead <= LEAD_C2;
              end else if (rx_byte == K_LEAD2) begin
                lead <= LEAD_C3;
              end
            end
            default: ;
          endcase
        end
      end
      if (state == ST_FIN && ack.flush_ok) begin
        cc  <= ncc;
        cur <= ncur;
      end
    end
  end

  // Plan and loop registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          sp_i      <= cur;
          sp_b      <= cur;
          span      <= '0;
          extra     <= 8'd0;
          chk_en    <= 1'b0;
          sh_up     <= 1'b0;
          sh_dst    <= cur;
          sh_cnt    <= '0;
          wr_p      <= 1'b0;
          ent       <= {lead, rx_byte};
          pre_mode  <= PRE_NONE;
          pre_byte  <= K_BEL;
          e_i       <= '0;
          e_b       <= '0;
          e_kind    <= 1'b0;
          post_en   <= 1'b0;
          post_byte <= K_SPACE;
          post_kind <= 1'b0;
          back_cnt  <= '0;
          ncc       <= cc;
          ncur      <= cur;
          if (do_enter) begin
            // Character entry
            if (cc >= CW'(LINE_CHARS)) begin
              pre_mode <= PRE_BYTE;
            end else if (ins) begin
              chk_en   <= 1'b1;
              sp_b     <= cc;
              extra    <= e_w + 8'(gap);
              sh_up    <= 1'b1;
              sh_dst   <= cc;
              sh_cnt   <= gap;
              wr_p     <= 1'b1;
              pre_mode <= PRE_CELL;
              e_i      <= cur + CW'(1);
              e_b      <= cc + CW'(1);
              back_cnt <= gap;
              ncc      <= cc + CW'(1);
              ncur     <= cur + CW'(1);
            end else begin
              wr_p     <= 1'b1;
              pre_mode <= PRE_CELL;
              ncur     <= cur + CW'(1);
              ncc      <= (cur == cc) ? cc + CW'(1) : cc;
            end
          end else begin
            case (phase)
              ESC_CSI: begin
                if (rx_byte == K_RIGHT) begin
                  if (cur < cc) begin
                    e_i  <= cur;
                    e_b  <= cur + CW'(1);
                    ncur <= cur + CW'(1);
                  end else begin
                    pre_mode <= PRE_BYTE;
                  end
                end else if (rx_byte == K_LEFT) begin
                  pre_mode <= PRE_BYTE;
                  if (cur != '0) begin
                    pre_byte <= K_BS;
                    ncur     <= cur - CW'(1);
                  end
                end
              end
              ESC_SS3: begin
                if (rx_byte == K_HOME) begin
                  back_cnt <= cur;
                  ncur     <= '0;
                end else if (rx_byte == K_END) begin
                  e_i  <= cur;
                  e_b  <= cc;
                  ncur <= cc;
                end
              end
              ESC_DEL_TRAIL: begin
                // Delete at cursor
                if (cur < cc) begin
                  chk_en   <= 1'b1;
                  sp_i     <= cur + CW'(1);
                  sp_b     <= cc;
                  extra    <= 8'd1 + 8'(gap);
                  sh_cnt   <= gap - CW'(1);
                  e_i      <= cur;
                  e_b      <= cc - CW'(1);
                  post_en  <= 1'b1;
                  back_cnt <= gap;
                  ncc      <= cc - CW'(1);
                end
              end
              ESC_IDLE: begin
                if (rx_byte == K_NL) begin
                  // Finished line: measure, echo NL, stream line and NL
                  sp_i      <= '0;
                  sp_b      <= cc;
                  pre_mode  <= PRE_BYTE;
                  pre_byte  <= K_NL;
                  e_b       <= cc;
                  e_kind    <= 1'b1;
                  post_en   <= 1'b1;
                  post_byte <= K_NL;
                  post_kind <= 1'b1;
                  ncc       <= '0;
                  ncur      <= '0;
                end else if ((rx_byte == K_RUB || rx_byte == K_BS) && cur != '0) begin
                  // Delete left of cursor
                  chk_en   <= 1'b1;
                  sp_b     <= cc;
                  extra    <= 8'd3 + 8'(gap);
                  sh_dst   <= cur - CW'(1);
                  sh_cnt   <= gap;
                  pre_mode <= PRE_BYTE;
                  pre_byte <= K_BS;
                  e_i      <= cur - CW'(1);
                  e_b      <= cc - CW'(1);
                  post_en  <= 1'b1;
                  back_cnt <= gap + CW'(1);
                  ncc      <= cc - CW'(1);
                  ncur     <= cur - CW'(1);
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_SPAN_ACC: begin
        span <= span + ((rd_code != LEAD_NONE) ? SW'(2) : SW'(1));
        sp_i <= sp_i + CW'(1);
      end
      ST_CHECK: begin
        // Redraw too long: ring the bell, leave the line alone
        if (chk_en && (8'(span) + extra > 8'(MAX_RESULTS))) begin
          sh_cnt   <= '0;
          wr_p     <= 1'b0;
          pre_mode <= PRE_BYTE;
          pre_byte <= K_BEL;
          e_b      <= e_i;
          post_en  <= 1'b0;
          back_cnt <= '0;
          ncc      <= cc;
          ncur     <= cur;
        end
      end
      ST_SHIFT_WR: begin
        sh_dst <= sh_src;
        sh_cnt <= sh_cnt - CW'(1);
      end
      ST_ECHO_LEAD: begin
        if (fire && rd_code == LEAD_NONE) e_i <= e_i + CW'(1);
      end
      ST_ECHO_BYTE: begin
        if (fire) e_i <= e_i + CW'(1);
      end
      ST_BACK: begin
        if (fire) back_cnt <= back_cnt - CW'(1);
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/console_line_editor_top.sv =====
// Console line editor for a VT100-style terminal.
// Input channel: one received terminal byte per word on rx_byte, taken when
// in_valid and in_ready are both high. Output channel: echo words (out_kind 0)
// that redraw the terminal, and on newline the finished line (out_kind 1,
// UTF-8 bytes plus NL, with line_length). last marks the final word of an input.
// One byte is handled at a time. The sequencer walks the line memory, which
// has one registered read and one write port: a measuring pass reads each
// character, a shift reads and then writes each moved character, and each
// character echoed from the line is read before its words are emitted.
// One word is held back internally to mark last; in_ready rises again once
// the final word has reached the output register, before it is taken.
// When out_ready is low the sequencer stops at its next word and resumes
// unchanged. Reset empties the line, homes the cursor, selects overwrite mode
// and clears any pending escape or lead byte; the line memory is not cleared.
module console_line_editor_top #(
  parameter int LINE_CHARS = cle_pkg::LINE_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_kind,
  output logic [5:0] line_length,
  output logic       last
);
  import cle_pkg::*;

  localparam int AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;

  logic               mem_rd_en;
  logic [AW-1:0]      mem_rd_addr;
  logic [ENTRY_W-1:0] mem_rd_data;
  logic               mem_wr_en;
  logic [AW-1:0]      mem_wr_addr;
  logic [ENTRY_W-1:0] mem_wr_data;
  cle_emit_t          emit;
  cle_ack_t           ack;

  // Line store
  cle_line_mem #(.LINE_CHARS(LINE_CHARS)) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Decode and edit sequencer
  cle_seq #(.LINE_CHARS(LINE_CHARS)) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .emit        (emit),
    .ack         (ack)
  );

  // Result stage
  cle_out u_out (
    .clk         (clk),
    .rst         (rst),
    .emit        (emit),
    .ack         (ack),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_kind    (out_kind),
    .line_length (line_length),
    .last        (last)
  );

endmodule
